// File: rtl/nfca_pkg.sv
package nfca_pkg;

    localparam int ARENA_WORDS = 1024;
    localparam int WORD_BYTES  = 4;

    localparam int ADDR_W   = $clog2(ARENA_WORDS);
    localparam int BYTES_W  = 12;
    localparam int NEED_MAX = ((1 << BYTES_W) - 1 + 2 * WORD_BYTES - 1) / WORD_BYTES;
    localparam int NEED_W   = $clog2(NEED_MAX + 1);
    localparam int SUM_W    = $clog2(ARENA_WORDS + NEED_MAX);
    localparam int BUDGET   = 2 * ARENA_WORDS;
    localparam int BUDGET_W = $clog2(BUDGET + 1);
    localparam int TOP_WORD = ARENA_WORDS - 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // one header: index of the next header and the busy bit
    typedef struct packed {
        logic [ADDR_W-1:0] next;
        logic              busy;
    } link_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        link_t             wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FREE,
        ST_EVAL_P,
        ST_EVAL_Q,
        ST_WR_P
    } state_t;

    // header contents written by the clearing pass after reset
    function automatic link_t clear_value(input logic [ADDR_W-1:0] addr);
        link_t v;
        v = '0;
        if (addr == '0) begin
            v.next = ADDR_W'(1);
            v.busy = 1'b1;
        end else if (addr == ADDR_W'(1)) begin
            v.next = ADDR_W'(TOP_WORD);
            v.busy = 1'b0;
        end else if (addr == ADDR_W'(TOP_WORD)) begin
            v.next = '0;
            v.busy = 1'b1;
        end
        return v;
    endfunction

endpackage

// File: rtl/next_fit_coalescing_allocator_top.sv
// Next-fit allocator over a 1024-word arena kept as a circular chain of
// block headers in one single-port-write RAM. A request is taken when start
// is high and busy is low; its result shows on block_address/failed for
// exactly one cycle with done high, and the receiver cannot stall it.
// After reset the block runs a clearing pass over all 1024 words (one RAM
// word a cycle) with busy high before the first request. Free: read the
// header, then write it back with its busy bit cleared; a null free
// answers without a RAM access. Allocate: each header visited is read, a
// free header also has its successor read, each merge writes a header,
// and a split writes the new header and then the chosen one; the walk is
// bounded by the two-lap limit and a budget of 2048 header steps, and a
// free header that does not fit is always followed by a busy one. The rate
// is set by the header RAM: every step of the walk needs one read of it,
// and the next address depends on that read.
module next_fit_coalescing_allocator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [nfca_pkg::BYTES_W-1:0]        request_bytes,
    input  logic [nfca_pkg::ADDR_W-1:0]         payload_address,
    output logic                                done,
    output logic [nfca_pkg::ADDR_W-1:0]         block_address,
    output logic                                failed
);

    // header RAM port, driven by the walk sequencer
    nfca_pkg::ram_req_t ram_req;
    nfca_pkg::link_t    rd_data;

    nfca_link_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // sequencer: clearing pass, free, next-fit walk with merging and split
    nfca_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .cmd             (cmd),
        .request_bytes   (request_bytes),
        .payload_address (payload_address),
        .rd_data         (rd_data),
        .ram_req         (ram_req),
        .busy            (busy),
        .done            (done),
        .block_address   (block_address),
        .failed          (failed)
    );

endmodule

// File: rtl/nfca_link_ram.sv
module nfca_link_ram (
    input  logic                clk,
    input  nfca_pkg::ram_req_t  req,
    output nfca_pkg::link_t     rd_data
);

    nfca_pkg::link_t mem [nfca_pkg::ARENA_WORDS];

    // write-first: a read of the word being written sees the new value
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.we && (req.waddr == req.raddr))
        begin
            rd_data <= req.wdata;
        end
        else
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

// File: rtl/nfca_seq.sv
module nfca_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                cmd,
    input  logic [nfca_pkg::BYTES_W-1:0]        request_bytes,
    input  logic [nfca_pkg::ADDR_W-1:0]         payload_address,
    input  nfca_pkg::link_t                     rd_data,
    output nfca_pkg::ram_req_t                  ram_req,
    output logic                                busy,
    output logic                                done,
    output logic [nfca_pkg::ADDR_W-1:0]         block_address,
    output logic                                failed
);

    localparam int AW = nfca_pkg::ADDR_W;

    nfca_pkg::state_t state_reg, state_next;
    logic [AW-1:0]                   p_reg, p_next;
    logic [AW-1:0]                   q_reg, q_next;
    logic [AW-1:0]                   split_reg, split_next;
    logic [AW-1:0]                   hint_reg, hint_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic [nfca_pkg::NEED_W-1:0]     need_reg, need_next;
    logic [nfca_pkg::BUDGET_W-1:0]   budget_reg, budget_next;
    logic                            laps_reg, laps_next;
    logic                            done_reg, done_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic                            fail_reg, fail_next;

    logic [nfca_pkg::BYTES_W:0]      bytes_round;
    logic [nfca_pkg::SUM_W-1:0]      end_sum;
    logic [AW-1:0]                   free_hdr;
    logic                            fits;

    // shared adder/compare: end of the needed block against the next header
    assign end_sum = nfca_pkg::SUM_W'(p_reg) + nfca_pkg::SUM_W'(need_reg);
    assign fits    = nfca_pkg::SUM_W'(q_reg) >= end_sum;

    assign bytes_round = (nfca_pkg::BYTES_W+1)'(request_bytes)
                       + (nfca_pkg::BYTES_W+1)'(2 * nfca_pkg::WORD_BYTES - 1);
    assign free_hdr    = payload_address - AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nfca_pkg::ST_CLEAR;
            clr_reg    <= '0;
            hint_reg   <= '0;
            done_reg   <= 1'b0;
            laps_reg   <= 1'b0;
            budget_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            hint_reg   <= hint_next;
            done_reg   <= done_next;
            laps_reg   <= laps_next;
            budget_reg <= budget_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        q_reg     <= q_next;
        split_reg <= split_next;
        need_reg  <= need_next;
        addr_reg  <= addr_next;
        fail_reg  <= fail_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        split_next    = split_reg;
        hint_next     = hint_reg;
        clr_next      = clr_reg;
        need_next     = need_reg;
        budget_next   = budget_reg;
        laps_next     = laps_reg;
        done_next     = 1'b0;
        addr_next     = addr_reg;
        fail_next     = fail_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = p_reg;
        ram_req.wdata = '0;
        ram_req.raddr = p_reg;

        unique case (state_reg)
            nfca_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = nfca_pkg::clear_value(clr_reg);
                if (clr_reg == AW'(nfca_pkg::TOP_WORD))
                begin
                    state_next = nfca_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            nfca_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    addr_next = '0;
                    fail_next = 1'b0;
                    if (cmd == nfca_pkg::CMD_ALLOC)
                    begin
                        need_next     = nfca_pkg::NEED_W'(bytes_round / nfca_pkg::WORD_BYTES);
                        p_next        = hint_reg;
                        ram_req.raddr = hint_reg;
                        budget_next   = nfca_pkg::BUDGET_W'(nfca_pkg::BUDGET);
                        laps_next     = 1'b0;
                        state_next    = nfca_pkg::ST_EVAL_P;
                    end
                    else if (payload_address != '0 &&
                             (AW+1)'(free_hdr) < (AW+1)'(nfca_pkg::ARENA_WORDS))
                    begin
                        p_next        = free_hdr;
                        ram_req.raddr = free_hdr;
                        state_next    = nfca_pkg::ST_FREE;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end

            nfca_pkg::ST_FREE:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = '{next: rd_data.next, busy: 1'b0};
                hint_next     = p_reg;
                done_next     = 1'b1;
                state_next    = nfca_pkg::ST_IDLE;
            end

            nfca_pkg::ST_EVAL_P:
            begin
                // rd_data is the header at p
                if (budget_reg == '0)
                begin
                    fail_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = nfca_pkg::ST_IDLE;
                end
                else
                begin
                    budget_next = budget_reg - nfca_pkg::BUDGET_W'(1);
                    if (!rd_data.busy)
                    begin
                        q_next        = rd_data.next;
                        ram_req.raddr = rd_data.next;
                        state_next    = nfca_pkg::ST_EVAL_Q;
                    end
                    else if (rd_data.next < p_reg && laps_reg)
                    begin
                        fail_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = nfca_pkg::ST_IDLE;
                    end
                    else
                    begin
                        if (rd_data.next < p_reg)
                        begin
                            laps_next = 1'b1;
                        end
                        p_next        = rd_data.next;
                        ram_req.raddr = rd_data.next;
                    end
                end
            end

            nfca_pkg::ST_EVAL_Q:
            begin
                // rd_data is the header at q, p is free and links to q
                if (!rd_data.busy)
                begin
                    if (budget_reg == '0)
                    begin
                        fail_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = nfca_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // merge q into p
                        budget_next   = budget_reg - nfca_pkg::BUDGET_W'(1);
                        ram_req.we    = 1'b1;
                        ram_req.wdata = '{next: rd_data.next, busy: 1'b0};
                        q_next        = rd_data.next;
                        ram_req.raddr = rd_data.next;
                    end
                end
                else if (fits)
                begin
                    split_next = end_sum[AW-1:0];
                    hint_next  = end_sum[AW-1:0];
                    addr_next  = p_reg + AW'(1);
                    if (q_reg != end_sum[AW-1:0])
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = end_sum[AW-1:0];
                        ram_req.wdata = '{next: q_reg, busy: 1'b0};
                        state_next    = nfca_pkg::ST_WR_P;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = '{next: q_reg, busy: 1'b1};
                        done_next     = 1'b1;
                        state_next    = nfca_pkg::ST_IDLE;
                    end
                end
                else if (q_reg < p_reg && laps_reg)
                begin
                    fail_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = nfca_pkg::ST_IDLE;
                end
                else
                begin
                    if (q_reg < p_reg)
                    begin
                        laps_next = 1'b1;
                    end
                    p_next        = q_reg;
                    ram_req.raddr = q_reg;
                    state_next    = nfca_pkg::ST_EVAL_P;
                end
            end

            nfca_pkg::ST_WR_P:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = '{next: split_reg, busy: 1'b1};
                done_next     = 1'b1;
                state_next    = nfca_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = nfca_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != nfca_pkg::ST_IDLE);
    assign done          = done_reg;
    assign block_address = addr_reg;
    assign failed        = fail_reg;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Slowest legal request is an allocate walking two full laps with merges.
    // The cap leaves room for ~290 requests at that cost plus sender gaps and
    // the clearing pass.
    localparam int CYCLE_CAP   = 5_000_000;
    localparam int DRAIN_TICKS = 40;

    // one expected answer per request
    typedef struct packed {
        logic [nfca_pkg::ADDR_W-1:0] block;
        logic                        failed;
    } outcome_t;

    // Scoreboard: keeps its own image of the header chain and the next-fit
    // hint, predicts each accepted request and checks answers in order.
    class allocator_scoreboard;
        nfca_pkg::link_t headers [nfca_pkg::ARENA_WORDS];
        int              next_fit_hint;
        outcome_t        expected_results [$];
        int              errors;

        function void clear_arena();
            foreach (headers[i]) headers[i] = '0;
            headers[0].next                  = nfca_pkg::ADDR_W'(1);
            headers[0].busy                  = 1'b1;
            headers[1].next                  = nfca_pkg::ADDR_W'(nfca_pkg::TOP_WORD);
            headers[1].busy                  = 1'b0;
            headers[nfca_pkg::TOP_WORD].next = '0;
            headers[nfca_pkg::TOP_WORD].busy = 1'b1;
            next_fit_hint = 0;
            errors = 0;
            expected_results.delete();
        endfunction

        // Next-fit walk from the hint, two laps at most, merging free runs
        // into the first free header. Returns the payload index or 0.
        function int carve_block(int bytes);
            int need;
            int p;
            int q;
            int split;
            int laps;
            int steps_left;
            need = (bytes + 2 * nfca_pkg::WORD_BYTES - 1) / nfca_pkg::WORD_BYTES;
            p = next_fit_hint;
            laps = 0;
            steps_left = nfca_pkg::BUDGET;
            while (laps < 2)
            begin
                if (steps_left == 0)
                    return 0;
                steps_left--;
                if (!headers[p].busy)
                begin
                    q = headers[p].next;
                    while (!headers[q].busy)
                    begin
                        if (steps_left == 0)
                            return 0;
                        steps_left--;
                        headers[p].next = headers[q].next;
                        headers[p].busy = 1'b0;
                        q = headers[p].next;
                    end
                    // plain index compare: a backward link never fits
                    if (q >= p + need)
                    begin
                        split = p + need;
                        if (q != split)
                        begin
                            headers[split].next = nfca_pkg::ADDR_W'(q);
                            headers[split].busy = 1'b0;
                            headers[p].next = nfca_pkg::ADDR_W'(split);
                        end
                        next_fit_hint = split % nfca_pkg::ARENA_WORDS;
                        headers[p].busy = 1'b1;
                        return p + 1;
                    end
                end
                if (int'(headers[p].next) < p)
                    laps++;
                p = headers[p].next;
            end
            return 0;
        endfunction

        function outcome_t note_request(logic c, logic [nfca_pkg::BYTES_W-1:0] b,
                                        logic [nfca_pkg::ADDR_W-1:0] a);
            outcome_t o;
            int r;
            int h;
            o = '0;
            if (c == nfca_pkg::CMD_ALLOC)
            begin
                r = carve_block(int'(b));
                if (r == 0)
                    o.failed = 1'b1;
                else
                    o.block = nfca_pkg::ADDR_W'(r);
            end
            else if (a != '0)
            begin
                // unchecked: whatever sits below the payload loses its busy bit
                h = int'(a) - 1;
                headers[h].busy = 1'b0;
                next_fit_hint = h;
            end
            expected_results.push_back(o);
            return o;
        endfunction

        function void check_result(logic [nfca_pkg::ADDR_W-1:0] addr, logic fl);
            outcome_t e;
            if (expected_results.size() == 0)
            begin
                $error("unexpected answer: block_address %0d failed %0b", addr, fl);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (addr !== e.block)
            begin
                $error("block_address: expected %0d, actual %0d", e.block, addr);
                errors++;
            end
            if (fl !== e.failed)
            begin
                $error("failed: expected %0b, actual %0b", e.failed, fl);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         cmd;
    logic [nfca_pkg::BYTES_W-1:0] request_bytes;
    logic [nfca_pkg::ADDR_W-1:0]  payload_address;
    logic                         done;
    logic [nfca_pkg::ADDR_W-1:0]  block_address;
    logic                         failed;

    allocator_scoreboard          sb;
    logic [nfca_pkg::ADDR_W-1:0]  live_blocks [$];   // payloads handed out, not yet freed
    int                           cycle_count = 0;

    next_fit_coalescing_allocator_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .request_bytes   (request_bytes),
        .payload_address (payload_address),
        .done            (done),
        .block_address   (block_address),
        .failed          (failed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Answers show for one cycle with done; sampled at the edge closing it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(block_address, failed);
    end

    // Present one request and hold it until taken (start high, busy low at
    // an edge). Keeps the list of live payloads current.
    task automatic issue(input logic c, input logic [nfca_pkg::BYTES_W-1:0] b,
                         input logic [nfca_pkg::ADDR_W-1:0] a);
        outcome_t o;
        int       hit;
        start           <= 1'b1;
        cmd             <= c;
        request_bytes   <= b;
        payload_address <= a;
        do @(posedge clk); while (busy);
        o = sb.note_request(c, b, a);
        if (c == nfca_pkg::CMD_ALLOC)
        begin
            if (!o.failed)
                live_blocks.push_back(o.block);
        end
        else
        begin
            hit = -1;
            foreach (live_blocks[i])
                if (hit < 0 && live_blocks[i] == a)
                    hit = i;
            if (hit >= 0)
                live_blocks.delete(hit);
        end
    endtask

    // Sender gap after a request: pct is the chance of each further idle cycle.
    task automatic idle_gap(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < pct);
        end
    endtask

    // Mostly well-formed traffic: allocates of mostly small sizes and frees
    // of live payloads; a few stray frees (null, random word) as noise.
    task automatic run_mix(input int count, input int pct);
        int                           roll;
        int                           size_roll;
        logic [nfca_pkg::BYTES_W-1:0] bytes;
        logic [nfca_pkg::ADDR_W-1:0]  addr;
        for (int n = 0; n < count; n++)
        begin
            roll  = $urandom_range(0, 99);
            bytes = nfca_pkg::BYTES_W'($urandom);
            addr  = nfca_pkg::ADDR_W'($urandom);      // ignored field on allocate
            if (roll < 6)
            begin
                if ($urandom_range(0, 3) == 0)
                    addr = '0;
                issue(nfca_pkg::CMD_FREE, bytes, addr);
            end
            else if (roll < 46 && live_blocks.size() != 0)
            begin
                addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                issue(nfca_pkg::CMD_FREE, bytes, addr);
            end
            else
            begin
                size_roll = $urandom_range(0, 9);
                if (size_roll < 7)
                    bytes = nfca_pkg::BYTES_W'($urandom_range(0, 64));
                else if (size_roll < 9)
                    bytes = nfca_pkg::BYTES_W'($urandom_range(0, 600));
                issue(nfca_pkg::CMD_ALLOC, bytes, addr);
            end
            idle_gap(pct);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = nfca_pkg::CMD_ALLOC;
        request_bytes   = '0;
        payload_address = '0;
        sb = new;
        sb.clear_arena();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        issue(nfca_pkg::CMD_ALLOC, 4095, 1023);   // 1025 words: can never fit
        issue(nfca_pkg::CMD_ALLOC, 4085, 0);      // one word more than the free block
        issue(nfca_pkg::CMD_ALLOC, 4084, 0);      // exact fit of the whole free block, no split
        issue(nfca_pkg::CMD_ALLOC, 0, 0);         // arena full
        issue(nfca_pkg::CMD_FREE, 0, 2);
        issue(nfca_pkg::CMD_ALLOC, 0, 0);         // header-only block, split
        issue(nfca_pkg::CMD_ALLOC, 1, 0);
        issue(nfca_pkg::CMD_ALLOC, 4, 0);
        issue(nfca_pkg::CMD_ALLOC, 5, 0);
        issue(nfca_pkg::CMD_ALLOC, 64, 0);
        issue(nfca_pkg::CMD_ALLOC, 4095, 0);
        issue(nfca_pkg::CMD_FREE, 4095, 0);       // null free
        issue(nfca_pkg::CMD_FREE, 0, 2);
        issue(nfca_pkg::CMD_FREE, 0, 2);          // same payload again
        issue(nfca_pkg::CMD_FREE, 0, 4);          // word below it is no header
        issue(nfca_pkg::CMD_FREE, 0, 1023);       // word that is no header
        issue(nfca_pkg::CMD_ALLOC, 8, 0);
        issue(nfca_pkg::CMD_FREE, 0, 1);          // base header
        issue(nfca_pkg::CMD_ALLOC, 8, 0);         // walk starts at the freed base
        issue(nfca_pkg::CMD_ALLOC, 2000, 0);
        issue(nfca_pkg::CMD_ALLOC, 3000, 0);
        issue(nfca_pkg::CMD_ALLOC, 12, 1023);

        // --- random, in sender-idle phases ---
        run_mix(67, 0);
        run_mix(67, 79);
        run_mix(67, 0);
        run_mix(67, 10);
        start <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/nfca_pkg.sv
rtl/nfca_link_ram.sv
rtl/nfca_seq.sv
rtl/next_fit_coalescing_allocator_top.sv
tb/sv/tb.sv
